// ----- src/ffa_pkg.sv -----
package ffa_pkg;

  localparam int GRANULE_BYTES  = 16;
  localparam int GRANULE_SHIFT  = 4;
  localparam int ADDR_W         = 16;
  localparam int REQ_W          = 16;
  localparam int CFG_W          = 13;
  localparam int NEED_W         = 13;
  localparam int RESET_GRANULES = 4096;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

// ----- src/ffa_hdr_store.sv -----
module ffa_hdr_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// First-fit heap allocator over 16-byte granules. Raise start with action,
// req_bytes and release_addr while busy is low; the word is taken at that edge.
// The result shows on data_addr and granted for one cycle with done high and
// cannot be held off. All chunk headers live in one header RAM (one read, one
// write per cycle, registered read data), so an item walks the free list one
// node at a time. After reset and after every cfg_we write, the whole RAM is
// swept once while busy stays high.
module first_fit_heap_allocator import ffa_pkg::*; #(
  parameter int HEAP_GRANULES   = 4096,
  parameter int SPLIT_MIN_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [REQ_W-1:0]  req_bytes,
  input  logic [ADDR_W-1:0] release_addr,
  output logic              done,
  output logic [ADDR_W-1:0] data_addr,
  output logic              granted,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int GW       = $clog2(HEAP_GRANULES);
  localparam int CW       = $clog2(HEAP_GRANULES + 1);
  localparam int SW       = GW + 1;
  localparam int WW       = GW + 18;
  localparam int HW       = 2 * GW + 1;
  localparam int SPLIT_GR = SPLIT_MIN_BYTES / GRANULE_BYTES;
  localparam int HG_RST   = (HEAP_GRANULES < RESET_GRANULES) ? HEAP_GRANULES
                                                             : RESET_GRANULES;

  typedef struct packed {
    logic [GW-1:0] size;
    logic [GW-1:0] next;
    logic          used;
  } hdr_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_HEAD, S_A_WALK, S_R_G, S_R_WALK, S_R_NX,
    S_W0, S_W1, S_W2
  } state_t;

  function automatic logic link_ok(input logic [GW-1:0] x, input logic [CW-1:0] lim);
    return (x != '0) && (WW'(x) < WW'(lim));
  endfunction

  state_t           state;
  logic [CW-1:0]    hg;
  logic [GW-1:0]    clr_addr;
  logic [NEED_W-1:0] need;
  logic [GW-1:0]    cur;
  logic [GW-1:0]    last;
  logic [SW-1:0]    steps;
  hdr_t             prev_hdr;
  hdr_t             g_hdr;
  logic [GW-1:0]    g_idx;
  logic [GW-1:0]    nx_idx;
  logic             nx_ok;
  logic             wq_en   [3];
  logic [GW-1:0]    wq_addr [3];
  hdr_t             wq_data [3];

  logic             mem_we;
  logic [GW-1:0]    mem_waddr;
  hdr_t             mem_wdata;
  logic [GW-1:0]    mem_raddr;
  logic [HW-1:0]    mem_rdata;
  hdr_t             rd;

  logic [REQ_W:0]    req_sum;
  logic [NEED_W-1:0] need_calc;
  logic [WW-1:0]     rel_g;
  logic              rel_ok;
  logic [WW-1:0]     cfg_clamp;
  hdr_t              clr_hdr;

  // allocate split
  logic [WW-1:0]    remain;
  logic             split;
  logic [GW-1:0]    tail;

  // release merge
  logic             mprev;
  logic [GW-1:0]    mcur;
  logic [WW-1:0]    cursz;
  logic             mnext;
  logic [WW-1:0]    finsz;
  hdr_t             fin_hdr;
  hdr_t             lnk_hdr;

  assign rd   = hdr_t'(mem_rdata);
  assign busy = (state != S_IDLE);

  ffa_hdr_store #(
    .DEPTH (HEAP_GRANULES),
    .WIDTH (HW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (HW'(mem_wdata)),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    req_sum   = {1'b0, req_bytes} + (REQ_W + 1)'(2 * GRANULE_BYTES - 1);
    need_calc = req_sum[REQ_W:GRANULE_SHIFT];
    rel_g     = WW'(release_addr[ADDR_W-1:GRANULE_SHIFT]) - WW'(1);
    rel_ok    = (release_addr[GRANULE_SHIFT-1:0] == '0) &&
                (release_addr[ADDR_W-1:GRANULE_SHIFT] != '0) &&
                (rel_g != '0) && (rel_g < WW'(hg));

    cfg_clamp = WW'(cfg_data);
    if (cfg_clamp < WW'(2)) begin
      cfg_clamp = WW'(2);
    end else if (cfg_clamp > WW'(HEAP_GRANULES)) begin
      cfg_clamp = WW'(HEAP_GRANULES);
    end

    clr_hdr      = '0;
    clr_hdr.next = (clr_addr == '0) ? GW'(1) : '0;
    clr_hdr.size = (clr_addr == GW'(1)) ? GW'(WW'(hg) - WW'(1)) : '0;

    remain = WW'(rd.size) - WW'(need);
    split  = (WW'(rd.size) > WW'(SPLIT_GR)) && (WW'(rd.size) > WW'(need));
    tail   = GW'(WW'(cur) + WW'(need));

    // prior neighbor is last, next neighbor is nx_idx, rd holds header of nx_idx
    mprev   = (last != '0) && (WW'(last) + WW'(prev_hdr.size) == WW'(g_idx));
    mcur    = mprev ? last : g_idx;
    cursz   = mprev ? WW'(prev_hdr.size) + WW'(g_hdr.size) : WW'(g_hdr.size);
    mnext   = nx_ok && (WW'(mcur) + cursz == WW'(nx_idx));
    finsz   = mnext ? cursz + WW'(rd.size) : cursz;
    fin_hdr.size = GW'(finsz);
    fin_hdr.next = mnext ? rd.next : nx_idx;
    fin_hdr.used = mprev ? prev_hdr.used : 1'b0;
    lnk_hdr      = prev_hdr;
    lnk_hdr.next = g_idx;

    unique case (state)
      S_IDLE:  mem_raddr = (action == ACT_RELEASE) ? GW'(rel_g) : '0;
      S_R_G:   mem_raddr = '0;
      default: mem_raddr = rd.next;
    endcase

    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = clr_hdr;
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_W0: begin
        mem_we = wq_en[0]; mem_waddr = wq_addr[0]; mem_wdata = wq_data[0];
      end
      S_W1: begin
        mem_we = wq_en[1]; mem_waddr = wq_addr[1]; mem_wdata = wq_data[1];
      end
      S_W2: begin
        mem_we = wq_en[2]; mem_waddr = wq_addr[2]; mem_wdata = wq_data[2];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state     <= S_CLEAR;
      hg        <= CW'(HG_RST);
      clr_addr  <= '0;
      granted   <= 1'b0;
      data_addr <= '0;
    end else if (cfg_we) begin
      hg       <= CW'(cfg_clamp);
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == GW'(HEAP_GRANULES - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + GW'(1);
          end
        end

        S_IDLE: begin
          if (start) begin
            data_addr <= '0;
            granted   <= 1'b0;
            last      <= '0;
            steps     <= '0;
            if (action == ACT_ALLOC) begin
              need <= need_calc;
              if (req_bytes == '0) begin
                done <= 1'b1;
              end else begin
                state <= S_A_HEAD;
              end
            end else begin
              g_idx <= GW'(rel_g);
              if (rel_ok) begin
                state <= S_R_G;
              end else begin
                done <= 1'b1;
              end
            end
          end
        end

        S_A_HEAD: begin
          prev_hdr <= rd;
          cur      <= rd.next;
          if (link_ok(rd.next, hg)) begin
            state <= S_A_WALK;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_A_WALK: begin
          if (WW'(rd.size) >= WW'(need)) begin
            wq_en[0]        <= 1'b1;
            wq_addr[0]      <= cur;
            wq_data[0].size <= split ? GW'(need) : rd.size;
            wq_data[0].next <= '0;
            wq_data[0].used <= 1'b1;
            wq_en[1]        <= 1'b1;
            wq_addr[1]      <= last;
            wq_data[1].size <= prev_hdr.size;
            wq_data[1].used <= prev_hdr.used;
            wq_data[1].next <= split ? tail : rd.next;
            wq_en[2]        <= split;
            wq_addr[2]      <= tail;
            wq_data[2].size <= GW'(remain);
            wq_data[2].next <= rd.next;
            wq_data[2].used <= 1'b0;
            data_addr <= ADDR_W'((WW'(cur) + WW'(1)) << GRANULE_SHIFT);
            granted   <= 1'b1;
            state     <= S_W0;
          end else if (steps == SW'(HEAP_GRANULES)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            prev_hdr <= rd;
            last     <= cur;
            cur      <= rd.next;
            steps    <= steps + SW'(1);
            if (!link_ok(rd.next, hg)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end

        S_R_G: begin
          g_hdr <= rd;
          if (rd.used && (rd.size != '0) &&
              (WW'(g_idx) + WW'(rd.size) <= WW'(hg))) begin
            state <= S_R_WALK;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_R_WALK: begin
          if (link_ok(rd.next, hg) && (rd.next < g_idx) &&
              (steps != SW'(HEAP_GRANULES))) begin
            last  <= rd.next;
            steps <= steps + SW'(1);
          end else begin
            // read of the following node was issued this cycle
            prev_hdr <= rd;
            nx_idx   <= rd.next;
            nx_ok    <= link_ok(rd.next, hg);
            state    <= S_R_NX;
          end
        end

        S_R_NX: begin
          wq_en[0]   <= 1'b1;
          wq_en[1]   <= 1'b1;
          if (mprev) begin
            wq_addr[0] <= g_idx;
            wq_data[0] <= '0;
            wq_addr[1] <= last;
            wq_data[1] <= fin_hdr;
          end else begin
            wq_addr[0] <= last;
            wq_data[0] <= lnk_hdr;
            wq_addr[1] <= g_idx;
            wq_data[1] <= fin_hdr;
          end
          wq_en[2]   <= mnext;
          wq_addr[2] <= nx_idx;
          wq_data[2] <= '0;
          granted    <= 1'b1;
          state      <= S_W0;
        end

        S_W0: state <= S_W1;
        S_W1: state <= S_W2;

        S_W2: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ffa_checker.sv -----
module ffa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] data_addr,
  input logic        granted
);

  // result only appears while busy is low, after any header writes
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  // an accepted word raises busy, or if rejected up front answers at once
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither raised busy nor answered");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (data_addr == 16'd0))
    else $error("failed result with nonzero address");

  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    (done && (data_addr != 16'd0)) |-> (granted && (data_addr[3:0] == 4'd0)))
    else $error("address not granule aligned or not granted");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (.*);

// ----- tb/sv/tb.sv -----
module tb;
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_MAX   = 4096;
  localparam int IDLE_LIMIT = 60000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } heap_reply_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              action;
  logic [REQ_W-1:0]  req_bytes;
  logic [ADDR_W-1:0] release_addr;
  logic              done;
  logic [ADDR_W-1:0] data_addr;
  logic              granted;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_data;

  first_fit_heap_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .req_bytes    (req_bytes),
    .release_addr (release_addr),
    .done         (done),
    .data_addr    (data_addr),
    .granted      (granted),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  // predicted heap image
  int unsigned chunk_size [HEAP_MAX];
  int unsigned chunk_next [HEAP_MAX];
  bit          chunk_used [HEAP_MAX];
  int unsigned heap_len;

  heap_reply_t       pending_replies[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int                fail_count;
  int                burst_left;
  int                idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void heap_rebuild(int unsigned v);
    if (v < 2) v = 2;
    if (v > HEAP_MAX) v = HEAP_MAX;
    heap_len = v;
    for (int i = 0; i < HEAP_MAX; i++) begin
      chunk_size[i] = 0;
      chunk_next[i] = 0;
      chunk_used[i] = 1'b0;
    end
    chunk_next[0] = 1;
    chunk_size[1] = heap_len - 1;
  endfunction

  function automatic bit link_valid(int unsigned g);
    return g != 0 && g < heap_len;
  endfunction

  function automatic int unsigned heap_alloc(int unsigned req);
    int unsigned need, prev, cur, steps, rest, tail;
    prev = 0;
    steps = 0;
    if (req == 0) return 0;
    need = (req + 2 * GRANULE_BYTES - 1) / GRANULE_BYTES;
    cur = chunk_next[0];
    while (link_valid(cur) && chunk_size[cur] < need && steps < HEAP_MAX) begin
      prev = cur;
      cur = chunk_next[cur];
      steps++;
    end
    if (!link_valid(cur) || chunk_size[cur] < need) return 0;
    rest = chunk_size[cur] - need;
    if (chunk_size[cur] * GRANULE_BYTES > 128 && rest >= 1) begin
      tail = cur + need;
      chunk_size[tail] = rest;
      chunk_next[tail] = chunk_next[cur];
      chunk_used[tail] = 1'b0;
      chunk_next[prev] = tail;
      chunk_size[cur] = need;
    end else begin
      chunk_next[prev] = chunk_next[cur];
    end
    chunk_used[cur] = 1'b1;
    chunk_next[cur] = 0;
    return (cur + 1) * GRANULE_BYTES;
  endfunction

  function automatic bit heap_release(int unsigned addr);
    int unsigned g, prev, cur, nx, steps;
    prev = 0;
    steps = 0;
    if (addr % GRANULE_BYTES != 0 || addr < GRANULE_BYTES) return 1'b0;
    g = addr / GRANULE_BYTES - 1;
    if (!link_valid(g) || !chunk_used[g]) return 1'b0;
    if (chunk_size[g] == 0 || g + chunk_size[g] > heap_len) return 1'b0;
    while (link_valid(chunk_next[prev]) && chunk_next[prev] < g && steps < HEAP_MAX) begin
      prev = chunk_next[prev];
      steps++;
    end
    chunk_used[g] = 1'b0;
    chunk_next[g] = chunk_next[prev];
    chunk_next[prev] = g;
    cur = g;
    if (prev != 0 && prev + chunk_size[prev] == g) begin
      chunk_size[prev] += chunk_size[g];
      chunk_next[prev] = chunk_next[g];
      chunk_size[g] = 0;
      chunk_next[g] = 0;
      chunk_used[g] = 1'b0;
      cur = prev;
    end
    nx = chunk_next[cur];
    if (link_valid(nx) && cur + chunk_size[cur] == nx) begin
      chunk_size[cur] += chunk_size[nx];
      chunk_next[cur] = chunk_next[nx];
      chunk_size[nx] = 0;
      chunk_next[nx] = 0;
      chunk_used[nx] = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_word(logic act, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] raddr);
    heap_reply_t  r;
    int unsigned  a;
    int           gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start        <= 1'b1;
    action       <= act;
    req_bytes    <= req;
    release_addr <= raddr;
    do @(posedge clk); while (busy);
    if (act == ACT_ALLOC) begin
      a = heap_alloc(req);
      r.addr = a[ADDR_W-1:0];
      r.ok = (a != 0);
      if (r.ok) live_blocks.push_back(r.addr);
    end else begin
      r.addr = '0;
      r.ok = heap_release(raddr);
    end
    pending_replies.push_back(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_heap_len(logic [CFG_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_rebuild(v);
    live_blocks.delete();
    repeat (2) @(posedge clk);
  endtask

  task automatic release_live(bit keep);
    int idx;
    logic [ADDR_W-1:0] a;
    idx = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[idx];
    if (!keep) live_blocks.delete(idx);
    send_word(ACT_RELEASE, REQ_W'($urandom), a);
  endtask

  task automatic test_edge_requests();
    send_word(ACT_ALLOC, 16'd0, 16'hFFFF);
    send_word(ACT_ALLOC, 16'hFFFF, 16'h0000);
    send_word(ACT_ALLOC, 16'd1, 16'h1234);
    send_word(ACT_ALLOC, 16'd16, 16'h0);
    send_word(ACT_ALLOC, 16'd112, 16'h0);
    send_word(ACT_ALLOC, 16'd65504, 16'h0);
    send_word(ACT_ALLOC, 16'd200, 16'h0);
  endtask

  task automatic test_release_cases();
    logic [ADDR_W-1:0] a;
    send_word(ACT_RELEASE, 16'h0, 16'd0);
    send_word(ACT_RELEASE, 16'h0, 16'd8);
    send_word(ACT_RELEASE, 16'h0, 16'd17);
    send_word(ACT_RELEASE, 16'h0, 16'hFFF0);
    send_word(ACT_RELEASE, 16'h0, 16'd16);
    a = live_blocks[0];
    send_word(ACT_RELEASE, 16'hFFFF, a);
    // same word again: used mark is already clear
    send_word(ACT_RELEASE, 16'h0, a);
    while (live_blocks.size() != 0) release_live(1'b0);
    // small heap: only a one-granule chunk, nothing fits
    write_heap_len(13'd2);
    send_word(ACT_ALLOC, 16'd1, 16'h0);
    // nine granules: chunk of eight, no split
    write_heap_len(13'd9);
    send_word(ACT_ALLOC, 16'd1, 16'h0);
    send_word(ACT_ALLOC, 16'd1, 16'h0);
    while (live_blocks.size() != 0) release_live(1'b0);
  endtask

  task automatic test_random_mix(logic [CFG_W-1:0] len, int count);
    int p;
    write_heap_len(len);
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 55 || (p < 90 && live_blocks.size() == 0)) begin
        p = $urandom_range(0, 99);
        if (p < 70)      send_word(ACT_ALLOC, REQ_W'($urandom_range(1, 160)), ADDR_W'($urandom));
        else if (p < 90) send_word(ACT_ALLOC, REQ_W'($urandom_range(1, 2000)), ADDR_W'($urandom));
        else if (p < 95) send_word(ACT_ALLOC, '0, ADDR_W'($urandom));
        else             send_word(ACT_ALLOC, REQ_W'($urandom), ADDR_W'($urandom));
      end else if (p < 90) begin
        release_live($urandom_range(0, 9) == 0);
      end else begin
        send_word(ACT_RELEASE, REQ_W'($urandom), ADDR_W'($urandom));
      end
      if (i == count / 2) drain();
    end
  endtask

  always @(posedge clk) begin
    heap_reply_t exp_r;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected word: data_addr %0h granted %0b", data_addr, granted);
        fail_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (data_addr !== exp_r.addr) begin
          $error("data_addr expected %0h actual %0h", exp_r.addr, data_addr);
          fail_count++;
        end
        if (granted !== exp_r.ok) begin
          $error("granted expected %0b actual %0b", exp_r.ok, granted);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    action       = ACT_ALLOC;
    req_bytes    = '0;
    release_addr = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    burst_left   = 0;
    heap_rebuild(RESET_GRANULES);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_requests();
    test_release_cases();
    test_random_mix(13'd4096, 180);
    test_random_mix(13'd37, 100);
    test_random_mix(13'd2, 20);
    test_random_mix(13'd9, 60);
    test_random_mix(13'd8191, 150);
    test_random_mix(13'd0, 20);
    test_random_mix(13'd300, 150);
    test_random_mix(13'd4096, 120);
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
